@@ hw/rtl/emrt_pkg.sv @@
// Package for the exact-match route table: operation and status codes,
// the stored entry layout and the default table depth.
// No dependencies.
`default_nettype none

package emrt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 6;
    localparam int COUNT_W    = 7;

    localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [31:0] dest_addr;
        logic [7:0]  prefix_mask;
        logic [31:0] gateway_addr;
        logic [15:0] out_iface;
    } route_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/exact_match_route_table.sv @@
// Exact-match route table kept densely packed in insertion order.
// Depends on emrt_pkg for codes, the entry layout and the default depth.
// Flush, unused codes and create on a full table go straight to the response. A key
// search reads and then compares each entry in turn (one memory read, one compare),
// stopping on a hit or after the last entry on a miss; delete then moves each later entry
// down one place by a read and a write. A miss or any delete on a full table reads every
// entry. One transaction is in flight at a time and s_ready returns with the result; the
// entry memory sets the pace. Active-low synchronous reset empties the table, not the memory.
`default_nettype none

module exact_match_route_table #(
    parameter int TABLE_DEPTH = emrt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [emrt_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [31:0]                     s_dest_addr,
    input  wire logic [7:0]                      s_prefix_mask,
    input  wire logic [31:0]                     s_gateway_addr,
    input  wire logic [15:0]                     s_out_iface,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [emrt_pkg::STATUS_W-1:0]        m_status,
    output logic [emrt_pkg::POSITION_W-1:0]      m_position,
    output logic [emrt_pkg::COUNT_W-1:0]         m_entry_count
);
    import emrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } state_t;

    route_entry_t entry_mem [TABLE_DEPTH];
    route_entry_t rd_data_reg;

    state_t                state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    route_entry_t          req_reg, req_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [POSITION_W-1:0] m_position_reg, m_position_next;
    logic [COUNT_W-1:0]    m_entry_count_reg, m_entry_count_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    route_entry_t          wr_data;
    logic                  key_hit;
    logic [IDX_W+POSITION_W-1:0] pos_ext;
    logic [CNT_W+COUNT_W-1:0]    cnt_ext;

    assign key_hit = (rd_data_reg.dest_addr == req_reg.dest_addr) &&
                     (rd_data_reg.prefix_mask == req_reg.prefix_mask);
    assign pos_ext = {{POSITION_W{1'b0}}, pos_reg};
    assign cnt_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_comb begin
        state_next         = state_reg;
        func_next          = func_reg;
        req_next           = req_reg;
        idx_next           = idx_reg;
        count_next         = count_reg;
        status_next        = status_reg;
        pos_next           = pos_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_position_next    = m_position_reg;
        m_entry_count_next = m_entry_count_reg;
        rd_en              = 1'b0;
        rd_addr            = idx_reg[IDX_W-1:0];
        wr_en              = 1'b0;
        wr_addr            = idx_reg[IDX_W-1:0];
        wr_data            = req_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next                = s_func;
                    req_next.dest_addr       = s_dest_addr;
                    req_next.prefix_mask     = s_prefix_mask;
                    req_next.gateway_addr    = s_gateway_addr;
                    req_next.out_iface       = s_out_iface;
                    idx_next                 = '0;
                    status_next              = ST_OK;
                    pos_next                 = '0;
                    unique case (s_func)
                        FUNC_CREATE: begin
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_SEARCH_RD;
                            end
                        end
                        FUNC_UPDATE, FUNC_DELETE, FUNC_LOOKUP: begin
                            state_next = S_SEARCH_RD;
                        end
                        FUNC_FLUSH: begin
                            count_next = '0;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SEARCH_RD: begin
                if (idx_reg == count_reg) begin
                    if (func_reg == FUNC_CREATE) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        pos_next   = count_reg[IDX_W-1:0];
                        count_next = CNT_W'(count_reg + 1'b1);
                    end else begin
                        status_next = ST_MISS;
                    end
                    state_next = S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP: begin
                if (key_hit) begin
                    pos_next = idx_reg[IDX_W-1:0];
                    priority if (func_reg == FUNC_CREATE) begin
                        status_next = ST_DUP;
                        state_next  = S_RESP;
                    end else if (func_reg == FUNC_UPDATE) begin
                        wr_en      = 1'b1;
                        state_next = S_RESP;
                    end else if (func_reg == FUNC_DELETE) begin
                        idx_next   = CNT_W'(idx_reg + 1'b1);
                        state_next = S_SHIFT_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    idx_next   = CNT_W'(idx_reg + 1'b1);
                    state_next = S_SEARCH_RD;
                end
            end
            S_SHIFT_RD: begin
                if (idx_reg == count_reg) begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(idx_reg - 1'b1);
                wr_data    = rd_data_reg;
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = S_SHIFT_RD;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = status_reg;
                    m_position_next    = pos_ext[POSITION_W-1:0];
                    m_entry_count_next = cnt_ext[COUNT_W-1:0];
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg          <= func_next;
        req_reg           <= req_next;
        idx_reg           <= idx_next;
        status_reg        <= status_next;
        pos_reg           <= pos_next;
        m_status_reg      <= m_status_next;
        m_position_reg    <= m_position_next;
        m_entry_count_reg <= m_entry_count_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

`default_nettype wire
